>>> sv/itam_pkg.sv
`timescale 1ns / 1ps
// itam_pkg: shared widths, register indexes, setup states and pipeline structs
// for the image tile address map. No dependencies.
package itam_pkg;

    localparam int CFG_W           = 13;
    localparam int COORD_W         = 12;
    localparam int INDEX_W         = 24;
    localparam int REG_IDX_W       = 2;
    localparam int MAX_DIM         = 4096;
    localparam int STEPS_PER_STAGE = 2;
    localparam int REM_STAGES      = COORD_W / STEPS_PER_STAGE;
    localparam int SETUP_CNT_W     = $clog2(CFG_W);

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = CFG_W'(480);
    localparam logic [CFG_W-1:0] RST_TILES_PER_SIDE = CFG_W'(2);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_TILES_PER_SIDE = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        SU_LOAD,
        SU_DIV,
        SU_SPAN,
        SU_READY
    } setup_state_t;

    typedef struct packed {
        logic             q;
        logic [CFG_W-1:0] rem;
    } div_step_t;

    // tile geometry handed from setup to the datapath
    typedef struct packed {
        logic             ready;
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] q_x;
        logic [CFG_W-1:0] span_x;
        logic [CFG_W-1:0] q_y;
        logic [CFG_W-1:0] span_y;
    } tile_cfg_t;

    typedef struct packed {
        logic [CFG_W-1:0]   rem;
        logic [COORD_W-1:0] dvd;
        logic [CFG_W-1:0]   dsr;
    } axis_t;

    typedef struct packed {
        logic  valid;
        logic  in_image;
        axis_t x;
        axis_t y;
    } rem_pipe_t;

    // one restoring division step
    function automatic div_step_t div_step(input logic [CFG_W-1:0] rem,
                                           input logic             din,
                                           input logic [CFG_W-1:0] dsr);
        logic [CFG_W:0] trial;
        div_step_t      res;
        trial = {rem, din};
        if (trial >= {1'b0, dsr}) begin
            res.q   = 1'b1;
            res.rem = CFG_W'(trial - {1'b0, dsr});
        end else begin
            res.q   = 1'b0;
            res.rem = trial[CFG_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> sv/image_tile_address_map.sv
`timescale 1ns / 1ps
// Image tile address map: for each output pixel coordinate of an N-by-N mosaic,
// returns the source coordinate (tile offset times N) and its linear index
// src_y*width+src_x; coordinates outside the image give zeros with
// m_coord_valid low. Takes one coordinate every cycle while s_ready is high
// (setup done, output not stalled), through one front stage that picks tile
// length and offset base, six stages of the pipelined remainder unit (two bits
// each) and two multiply stages ending in the output register. After reset and
// after every configuration write, a bit-serial divider derives the tile
// lengths, during which s_ready is low. Depends on itam_pkg and its submodules.
module image_tile_address_map
    import itam_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [COORD_W-1:0]   s_out_x,
    input  logic [COORD_W-1:0]   s_out_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COORD_W-1:0]   m_src_x,
    output logic [COORD_W-1:0]   m_src_y,
    output logic [INDEX_W-1:0]   m_src_index,
    output logic                 m_coord_valid
);

    tile_cfg_t tcfg;
    logic      adv;
    logic      front_valid_reg;
    rem_pipe_t front_reg, front_next;
    rem_pipe_t pipe [0:REM_STAGES];

    function automatic axis_t axis_init(input logic [COORD_W-1:0] pos,
                                        input logic [CFG_W-1:0]   q,
                                        input logic [CFG_W-1:0]   span);
        logic [CFG_W-1:0] pos_w;
        axis_t            a;
        pos_w = CFG_W'(pos);
        a.rem = '0;
        if (pos_w < span) begin
            a.dsr = q + 1'b1;
            a.dvd = pos;
        end else begin
            a.dsr = q;
            a.dvd = COORD_W'(pos_w - span);
        end
        return a;
    endfunction

    itam_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tcfg      (tcfg)
    );

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv && tcfg.ready;

    always_comb begin
        front_next.valid    = s_valid && tcfg.ready;
        front_next.in_image = (CFG_W'(s_out_x) < tcfg.w) && (CFG_W'(s_out_y) < tcfg.h);
        front_next.x        = axis_init(s_out_x, tcfg.q_x, tcfg.span_x);
        front_next.y        = axis_init(s_out_y, tcfg.q_y, tcfg.span_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (adv) begin
            front_valid_reg <= front_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            front_reg <= front_next;
        end
    end

    always_comb begin
        pipe[0]       = front_reg;
        pipe[0].valid = front_valid_reg;
    end

    for (genvar k = 0; k < REM_STAGES; k++) begin : g_rem
        itam_rem_stage u_rem (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .pipe_in  (pipe[k]),
            .pipe_out (pipe[k+1])
        );
    end

    itam_scale u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .pipe_in       (pipe[REM_STAGES]),
        .n             (tcfg.n),
        .w             (tcfg.w),
        .m_valid       (m_valid),
        .m_src_x       (m_src_x),
        .m_src_y       (m_src_y),
        .m_src_index   (m_src_index),
        .m_coord_valid (m_coord_valid)
    );

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_coord_valid |->
            m_src_x == '0 && m_src_y == '0 && m_src_index == '0)
        else $error("outside coordinate with non-zero source fields");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("input taken while tile geometry is being rederived");

    a_no_entry_in_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        !tcfg.ready && !m_valid |=> !front_valid_reg)
        else $error("item entered pipeline during setup");

endmodule

>>> sv/itam_setup.sv
`timescale 1ns / 1ps
// itam_setup: configuration registers and bit-serial divider that derives
// tile length and long-tile span per axis. Depends on itam_pkg.
module itam_setup
    import itam_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output tile_cfg_t            tcfg
);

    logic [CFG_W-1:0]       width_reg, height_reg, tiles_reg;
    setup_state_t           state_reg, state_next;
    logic [SETUP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0]       dvd_x_reg, dvd_y_reg, rem_x_reg, rem_y_reg;
    logic [CFG_W-1:0]       span_x_reg, span_y_reg;

    logic [CFG_W-1:0]   w_eff, h_eff, n_eff;
    div_step_t          step_x, step_y;
    logic [2*CFG_W-1:0] prod_x, prod_y;

    assign w_eff  = (32'(width_reg) > MAX_DIM)  ? CFG_W'(MAX_DIM) : width_reg;
    assign h_eff  = (32'(height_reg) > MAX_DIM) ? CFG_W'(MAX_DIM) : height_reg;
    assign n_eff  = (tiles_reg == '0) ? CFG_W'(1) : tiles_reg;
    assign step_x = div_step(rem_x_reg, dvd_x_reg[CFG_W-1], n_eff);
    assign step_y = div_step(rem_y_reg, dvd_y_reg[CFG_W-1], n_eff);
    assign prod_x = (2*CFG_W)'(rem_x_reg) * ((2*CFG_W)'(dvd_x_reg) + (2*CFG_W)'(1));
    assign prod_y = (2*CFG_W)'(rem_y_reg) * ((2*CFG_W)'(dvd_y_reg) + (2*CFG_W)'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            tiles_reg  <= RST_TILES_PER_SIDE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:    width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT:   height_reg <= cfg_wdata;
                REG_TILES_PER_SIDE: tiles_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_LOAD;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            SU_LOAD: begin
                state_next = SU_DIV;
                cnt_next   = '0;
            end
            SU_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SETUP_CNT_W'(CFG_W - 1)) begin
                    state_next = SU_SPAN;
                end
            end
            SU_SPAN:  state_next = SU_READY;
            SU_READY: state_next = SU_READY;
            default:  state_next = SU_LOAD;
        endcase
        if (cfg_we) begin
            state_next = SU_LOAD;
        end
    end

    // quotient shifts into the dividend register; remainder is left in rem
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            SU_LOAD: begin
                dvd_x_reg <= w_eff;
                dvd_y_reg <= h_eff;
                rem_x_reg <= '0;
                rem_y_reg <= '0;
            end
            SU_DIV: begin
                dvd_x_reg <= {dvd_x_reg[CFG_W-2:0], step_x.q};
                dvd_y_reg <= {dvd_y_reg[CFG_W-2:0], step_y.q};
                rem_x_reg <= step_x.rem;
                rem_y_reg <= step_y.rem;
            end
            SU_SPAN: begin
                span_x_reg <= prod_x[CFG_W-1:0];
                span_y_reg <= prod_y[CFG_W-1:0];
            end
            default: ;
        endcase
    end

    assign tcfg.ready  = (state_reg == SU_READY);
    assign tcfg.n      = n_eff;
    assign tcfg.w      = w_eff;
    assign tcfg.h      = h_eff;
    assign tcfg.q_x    = dvd_x_reg;
    assign tcfg.span_x = span_x_reg;
    assign tcfg.q_y    = dvd_y_reg;
    assign tcfg.span_y = span_y_reg;

endmodule

>>> sv/itam_rem_stage.sv
`timescale 1ns / 1ps
// itam_rem_stage: one register stage of the pipelined remainder unit, two
// restoring steps per axis. Depends on itam_pkg.
module itam_rem_stage
    import itam_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  rem_pipe_t pipe_in,
    output rem_pipe_t pipe_out
);

    logic      valid_reg;
    rem_pipe_t data_reg;
    rem_pipe_t data_next;

    always_comb begin
        div_step_t sx;
        div_step_t sy;
        data_next = pipe_in;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            sx = div_step(data_next.x.rem, data_next.x.dvd[COORD_W-1], data_next.x.dsr);
            sy = div_step(data_next.y.rem, data_next.y.dvd[COORD_W-1], data_next.y.dsr);
            data_next.x.rem = sx.rem;
            data_next.y.rem = sy.rem;
            data_next.x.dvd = {data_next.x.dvd[COORD_W-2:0], 1'b0};
            data_next.y.dvd = {data_next.y.dvd[COORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= pipe_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        pipe_out       = data_reg;
        pipe_out.valid = valid_reg;
    end

endmodule

>>> sv/itam_scale.sv
`timescale 1ns / 1ps
// itam_scale: scales tile offsets by the tile count, then forms the linear
// index in the output register. Depends on itam_pkg.
module itam_scale
    import itam_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  rem_pipe_t          pipe_in,
    input  logic [CFG_W-1:0]   n,
    input  logic [CFG_W-1:0]   w,
    output logic               m_valid,
    output logic [COORD_W-1:0] m_src_x,
    output logic [COORD_W-1:0] m_src_y,
    output logic [INDEX_W-1:0] m_src_index,
    output logic               m_coord_valid
);

    logic               a_valid_reg, a_in_image_reg;
    logic [COORD_W-1:0] sx_reg, sy_reg;
    logic               out_valid_reg, out_in_image_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [INDEX_W-1:0] out_index_reg;

    logic [2*CFG_W-1:0] prod_x, prod_y;
    logic [COORD_W-1:0] sx_next, sy_next;
    logic [INDEX_W:0]   index_next;

    assign prod_x  = (2*CFG_W)'(pipe_in.x.rem) * (2*CFG_W)'(n);
    assign prod_y  = (2*CFG_W)'(pipe_in.y.rem) * (2*CFG_W)'(n);
    assign sx_next = pipe_in.in_image ? prod_x[COORD_W-1:0] : '0;
    assign sy_next = pipe_in.in_image ? prod_y[COORD_W-1:0] : '0;

    assign index_next = (INDEX_W+1)'(sy_reg) * (INDEX_W+1)'(w) + (INDEX_W+1)'(sx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg   <= pipe_in.valid;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_in_image_reg   <= pipe_in.in_image;
            sx_reg           <= sx_next;
            sy_reg           <= sy_next;
            out_in_image_reg <= a_in_image_reg;
            out_x_reg        <= sx_reg;
            out_y_reg        <= sy_reg;
            out_index_reg    <= index_next[INDEX_W-1:0];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_src_x       = out_x_reg;
    assign m_src_y       = out_y_reg;
    assign m_src_index   = out_index_reg;
    assign m_coord_valid = out_in_image_reg;

endmodule

>>> tb/sv/image_tile_address_map_tb.sv
`timescale 1ns / 1ps
// Testbench for image_tile_address_map: drives coordinate transfers under the reset,
// edge-case and random geometries and checks every result against an in-bench mosaic
// address predictor. Depends on itam_pkg and the image_tile_address_map RTL.
module image_tile_address_map_tb;
    import itam_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1930;

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [INDEX_W-1:0] src_index;
        logic               coord_valid;
    } src_pixel_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [COORD_W-1:0]   s_out_x;
    logic [COORD_W-1:0]   s_out_y;
    logic                 m_valid;
    logic                 m_ready;
    logic [COORD_W-1:0]   m_src_x;
    logic [COORD_W-1:0]   m_src_y;
    logic [INDEX_W-1:0]   m_src_index;
    logic                 m_coord_valid;

    logic [CFG_W-1:0] geo_width;
    logic [CFG_W-1:0] geo_height;
    logic [CFG_W-1:0] geo_tiles;

    src_pixel_t pending_pixels[$];
    bit         failed;
    bit         quiet;
    int         coords_sent;

    image_tile_address_map dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_out_x       (s_out_x),
        .s_out_y       (s_out_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_src_x       (m_src_x),
        .m_src_y       (m_src_y),
        .m_src_index   (m_src_index),
        .m_coord_valid (m_coord_valid)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // offset inside the tile holding pos, scaled by the tile count
    function automatic int unsigned tile_source(input int unsigned pos,
                                                input int unsigned size,
                                                input int unsigned n);
        int unsigned q;
        int unsigned r;
        int unsigned long_span;
        int unsigned off;
        q = size / n;
        r = size % n;
        long_span = r * (q + 1);
        if (pos < long_span) begin
            off = pos % (q + 1);
        end else begin
            if (q == 0) return 0;
            off = (pos - long_span) % q;
        end
        return off * n;
    endfunction

    function automatic src_pixel_t map_coord(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
        src_pixel_t  px;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned sx;
        int unsigned sy;
        int unsigned idx;
        px = '0;
        w = clamp_dim(geo_width);
        h = clamp_dim(geo_height);
        n = (geo_tiles == 0) ? 1 : int'(geo_tiles);
        if (x >= w || y >= h) return px;
        sx = tile_source(x, w, n);
        sy = tile_source(y, h, n);
        idx = sy * w + sx;
        px.src_x       = sx[COORD_W-1:0];
        px.src_y       = sy[COORD_W-1:0];
        px.src_index   = idx[INDEX_W-1:0];
        px.coord_valid = 1'b1;
        return px;
    endfunction

    function automatic int idle_draw();
        return quiet ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:    geo_width  = value;
            REG_IMAGE_HEIGHT:   geo_height = value;
            REG_TILES_PER_SIDE: geo_tiles  = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic [CFG_W-1:0] n);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_TILES_PER_SIDE, n);
    endtask

    // called just after a falling edge; returns just after one
    task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_out_x <= x;
        s_out_y <= y;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_pixels.push_back(map_coord(x, y));
        coords_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic test_reset_geometry();
        send_coord(12'd0, 12'd0);
        send_coord(12'd639, 12'd479);
        send_coord(12'd319, 12'd239);
        send_coord(12'd320, 12'd240);
        send_coord(12'd640, 12'd0);
        send_coord(12'd0, 12'd480);
        send_coord(12'hFFF, 12'hFFF);
        wait_for_results();
    endtask

    task automatic test_edge_geometries();
        // zero width: nothing is inside
        set_geometry(13'd0, 13'd480, 13'd2);
        send_coord(12'd0, 12'd0);
        wait_for_results();
        // oversize dimensions clamp, zero tiles means identity
        set_geometry(13'h1FFF, 13'd4097, 13'd0);
        send_coord(12'hFFF, 12'hFFF);
        send_coord(12'd0, 12'd0);
        send_coord(12'd1234, 12'd2345);
        wait_for_results();
        // more tiles than pixels
        set_geometry(13'd5, 13'd3, 13'd7);
        send_coord(12'd4, 12'd2);
        send_coord(12'd3, 12'd1);
        wait_for_results();
        // uneven split: long tiles first
        set_geometry(13'd7, 13'd10, 13'd3);
        send_coord(12'd2, 12'd9);
        send_coord(12'd6, 12'd3);
        wait_for_results();
        set_geometry(13'd1, 13'd1, 13'd4096);
        send_coord(12'd0, 12'd0);
        send_coord(12'd1, 12'd0);
        wait_for_results();
        // write to the unmapped register index (ignored by the design), then rewrite all three
        write_reg(REG_SPARE, 13'h1FFF);
        set_geometry(13'd4096, 13'd4096, 13'h1FFF);
        send_coord(12'hFFF, 12'd0);
        wait_for_results();
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'd4096;
            3: return 13'h1FFF;
            4: return CFG_W'($urandom_range(4097, 8191));
            5, 6: return CFG_W'($urandom_range(1, 64));
            default: return CFG_W'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_tiles(input int unsigned w);
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'h1FFF;
            3: return 13'd4096;
            4, 5, 6: return CFG_W'($urandom_range(1, 16));
            7: return CFG_W'($urandom_range(1, (w == 0) ? 1 : w));
            default: return CFG_W'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned size);
        if (size == 0 || $urandom_range(0, 99) < 15) return COORD_W'($urandom());
        return COORD_W'($urandom_range(0, size - 1));
    endfunction

    task automatic test_random_mosaics();
        int          limit;
        int          burst;
        int unsigned w;
        int unsigned h;
        limit = coords_sent + RANDOM_ITEMS;
        while (coords_sent < limit) begin
            set_geometry(pick_dim(), pick_dim(), 13'd0);
            write_reg(REG_TILES_PER_SIDE, pick_tiles(clamp_dim(geo_width)));
            w = clamp_dim(geo_width);
            h = clamp_dim(geo_height);
            quiet = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(40, 120);
            repeat (burst) send_coord(pick_coord(w), pick_coord(h));
            wait_for_results();
        end
        quiet = 1'b0;
    endtask

    // result side: random stall per transfer
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn == 1'b1);
        @(negedge aclk);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        src_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d idx=%0d valid=%0b", $time,
                         m_src_x, m_src_y, m_src_index, m_coord_valid);
                failed = 1'b1;
            end else begin
                want = pending_pixels.pop_front();
                if (m_src_x !== want.src_x) begin
                    $display("%0t: src_x expected %0d actual %0d", $time, want.src_x, m_src_x);
                    failed = 1'b1;
                end
                if (m_src_y !== want.src_y) begin
                    $display("%0t: src_y expected %0d actual %0d", $time, want.src_y, m_src_y);
                    failed = 1'b1;
                end
                if (m_src_index !== want.src_index) begin
                    $display("%0t: src_index expected %0d actual %0d", $time,
                             want.src_index, m_src_index);
                    failed = 1'b1;
                end
                if (m_coord_valid !== want.coord_valid) begin
                    $display("%0t: coord_valid expected %0b actual %0b", $time,
                             want.coord_valid, m_coord_valid);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("image_tile_address_map verification failed");
        $finish;
    end

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_out_x     = '0;
        s_out_y     = '0;
        failed      = 1'b0;
        quiet       = 1'b0;
        coords_sent = 0;
        geo_width   = RST_IMAGE_WIDTH;
        geo_height  = RST_IMAGE_HEIGHT;
        geo_tiles   = RST_TILES_PER_SIDE;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_reset_geometry();
        test_edge_geometries();
        test_random_mosaics();
        wait_for_results();
        if (!failed) begin
            $display("image_tile_address_map verification clean");
        end else begin
            $display("image_tile_address_map verification failed");
        end
        $finish;
    end

endmodule
